/* src/tsm_pkg.sv */
package tsm_pkg;

  localparam int unsigned NODE_COUNT   = 1024;
  localparam int unsigned PATTERN_BITS = 64;
  localparam int unsigned LETTERS      = 26;

  localparam int unsigned NODE_W   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned PB_W     = $clog2(PATTERN_BITS);
  localparam int unsigned OP_W     = 2;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned NODE_P_W = 10;
  localparam int unsigned LEN_W    = 6;

  typedef logic [PATTERN_BITS-1:0] vec_t;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_EDGE   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } tsm_state_e;

  typedef struct packed {
    logic clear;   // clearing pass writes one node entry
    logic accept;  // request taken this cycle
    logic exec;    // node data back from memory, finish request
  } tsm_cmd_t;

  typedef struct packed {
    logic clear_done;
  } tsm_status_t;

endpackage

/* src/tsm_ram.sv */
module tsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                 wr_data_i,
  input  logic                             rd_en_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                 rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/tsm_ctrl.sv */
module tsm_ctrl
  import tsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  tsm_status_t status_i,
  output tsm_cmd_t    cmd_o,
  output logic        busy_o
);

  tsm_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.clear  = (state_q == ST_CLEAR);
  assign cmd_o.accept = (state_q == ST_IDLE) && start_i;
  assign cmd_o.exec   = (state_q == ST_EXEC);
  assign busy_o       = (state_q != ST_IDLE);

endmodule

/* src/tsm_dp.sv */
module tsm_dp
  import tsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsm_cmd_t            cmd_i,
  output tsm_status_t         status_o,
  input  logic [OP_W-1:0]     opcode_i,
  input  logic [LETTER_W-1:0] range_first_char_i,
  input  logic [LETTER_W-1:0] range_last_char_i,
  input  logic [NODE_P_W-1:0] parent_node_i,
  input  logic [NODE_P_W-1:0] child_node_i,
  input  logic [LETTER_W-1:0] edge_char_i,
  input  logic [NODE_P_W-1:0] query_node_i,
  input  logic [LEN_W-1:0]    min_length_i,
  input  logic [LEN_W-1:0]    max_length_i,
  output logic                result_valid_o,
  output logic                found_o
);

  // pattern state
  vec_t             cmask_q [LETTERS];
  logic [PB_W-1:0]  plen_q, plen_d;

  // request registers
  opcode_e             op_q;
  logic [LETTER_W-1:0] first_q, last_q;
  logic [NODE_W-1:0]   child_q;
  logic                parent_ok_q, child_ok_q, query_ok_q;
  vec_t                cls_q;
  logic [PB_W-1:0]     bit_q;

  logic [NODE_W-1:0]   clr_cnt_q;
  logic                valid_q, found_q;

  // node memory, {seen, active}
  logic                    ram_we, ram_re;
  logic [NODE_W-1:0]       ram_waddr, ram_raddr;
  logic [2*PATTERN_BITS-1:0] ram_wdata, ram_rdata;

  logic [LEN_W-1:0] lo_len;
  vec_t             pa, ps, act;
  logic             is_edge_in;

  assign is_edge_in = (opcode_i == OP_EDGE);
  assign lo_len     = (min_length_i == '0) ? LEN_W'(1) : min_length_i;

  tsm_ram #(
    .WIDTH (2 * PATTERN_BITS),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign ram_re    = cmd_i.accept;
  assign ram_raddr = is_edge_in ? NODE_W'(parent_node_i) : NODE_W'(query_node_i);

  assign pa  = parent_ok_q ? ram_rdata[PATTERN_BITS-1:0] : '0;
  assign ps  = parent_ok_q ? ram_rdata[2*PATTERN_BITS-1:PATTERN_BITS] : '0;
  assign act = ((pa << 1) & cls_q) | vec_t'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = child_q;
    ram_wdata = {ps | act, act};
    if (cmd_i.clear) begin
      // root comes out of reset with only the empty-prefix bit active
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = {vec_t'(0), (clr_cnt_q == '0) ? vec_t'(1) : vec_t'(0)};
    end else if (cmd_i.exec && op_q == OP_EDGE && child_ok_q) begin
      ram_we = 1'b1;
    end
  end

  assign status_o.clear_done = (clr_cnt_q == NODE_W'(NODE_COUNT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + NODE_W'(1);
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q        <= opcode_e'(opcode_i);
      first_q     <= range_first_char_i;
      last_q      <= range_last_char_i;
      child_q     <= NODE_W'(child_node_i);
      parent_ok_q <= (32'(parent_node_i) < NODE_COUNT);
      child_ok_q  <= (32'(child_node_i) < NODE_COUNT);
      cls_q       <= (32'(edge_char_i) < LETTERS) ? cmask_q[edge_char_i] : '0;
      query_ok_q  <= (lo_len <= max_length_i) && (32'(lo_len) < PATTERN_BITS)
                     && (32'(query_node_i) < NODE_COUNT);
      bit_q       <= PB_W'(lo_len);
    end
  end

  // pattern append
  always_comb begin
    plen_d = plen_q;
    if (cmd_i.exec && op_q == OP_APPEND && 32'(plen_q) < PATTERN_BITS - 1) begin
      plen_d = plen_q + PB_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0;
      for (int k = 0; k < LETTERS; k++) begin
        cmask_q[k] <= vec_t'(1);
      end
    end else begin
      plen_q <= plen_d;
      if (plen_d != plen_q) begin
        for (int k = 0; k < LETTERS; k++) begin
          if (first_q <= LETTER_W'(k) && LETTER_W'(k) <= last_q) begin
            cmask_q[k] <= cmask_q[k] | (vec_t'(1) << plen_d);
          end
        end
      end
    end
  end

  // query result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.exec && op_q == OP_QUERY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      found_q <= query_ok_q && ram_rdata[PATTERN_BITS + 32'(bit_q)];
    end
  end

  assign result_valid_o = valid_q;
  assign found_o        = found_q;

endmodule

/* src/tree_shift_and_matcher_core.sv */
// Shift-And prefix matcher over a tree of letters. Busy is high for the
// cycle after start is taken, while the node memory's registered read of
// the parent (or queried) node comes back and, for an edge, the child
// entry is written. A query answer is shown on found_o with result_valid_o
// high for one cycle, from the result registers that follow the node
// memory read; the receiver must take it then. After reset the block runs
// a clearing pass that writes all NODE_COUNT (1024) node entries with busy
// high before the first request is taken.
module tree_shift_and_matcher_core
  import tsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     opcode_i,
  input  logic [LETTER_W-1:0] range_first_char_i,
  input  logic [LETTER_W-1:0] range_last_char_i,
  input  logic [NODE_P_W-1:0] parent_node_i,
  input  logic [NODE_P_W-1:0] child_node_i,
  input  logic [LETTER_W-1:0] edge_char_i,
  input  logic [NODE_P_W-1:0] query_node_i,
  input  logic [LEN_W-1:0]    min_length_i,
  input  logic [LEN_W-1:0]    max_length_i,
  output logic                result_valid_o,
  output logic                found_o
);

  tsm_cmd_t    cmd;
  tsm_status_t status;

  tsm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  tsm_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .opcode_i           (opcode_i),
    .range_first_char_i (range_first_char_i),
    .range_last_char_i  (range_last_char_i),
    .parent_node_i      (parent_node_i),
    .child_node_i       (child_node_i),
    .edge_char_i        (edge_char_i),
    .query_node_i       (query_node_i),
    .min_length_i       (min_length_i),
    .max_length_i       (max_length_i),
    .result_valid_o     (result_valid_o),
    .found_o            (found_o)
  );

endmodule
